### sv/gbl_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the Goldbach partition lister.
// No dependencies; compiled first.
package gbl_pkg;

  localparam int N_W   = 9;  // input number
  localparam int SP_W  = 8;  // smaller prime
  localparam int LP_W  = 9;  // larger prime
  localparam int D_W   = 5;  // trial divisor, reaches 23 at most
  localparam int REM_W = 5;  // remainder, always below the divisor
  localparam int CNT_W = 7;  // pair count, holds MAX_RES itself

  localparam logic [CNT_W-1:0] MAX_RES     = 7'd64;
  localparam logic [N_W-1:0]   FIRST_PRIME = 9'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CAND,
    ST_DIV_HI,
    ST_DIV_LO,
    ST_PAIR,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic load;
    logic start_test;
    logic sel_large;
    logic next_cand;
    logic div_hi;
    logic inc_d;
    logic record_pair;
    logic push_final;
  } cmd_t;

  typedef struct packed {
    logic cand_end;
    logic sel_j;
    logic v_lt2;
    logic sq_gt;
    logic rem_zero;
    logic has_pend;
    logic out_free;
    logic cnt_full;
  } stat_t;

endpackage

### sv/gbl_if.sv
`timescale 1ns / 1ps
// Request channels of the Goldbach partition lister: number in, pair out.
// Depends on gbl_pkg for the field widths.
interface gbl_in_if
  import gbl_pkg::*;
();
  logic           valid;
  logic           ready;
  logic [N_W-1:0] n;

  modport source (output valid, output n, input ready);
  modport sink (input valid, input n, output ready);
endinterface

interface gbl_out_if
  import gbl_pkg::*;
();
  logic            valid;
  logic            ready;
  logic [SP_W-1:0] small_prime;
  logic [LP_W-1:0] large_prime;
  logic            found;
  logic            last;

  modport source (output valid, output small_prime, output large_prime, output found,
                  output last, input ready);
  modport sink (input valid, input small_prime, input large_prime, input found,
                input last, output ready);
endinterface

### sv/goldbach_partition_lister_unit.sv
`timescale 1ns / 1ps
// Search: each candidate is set up, then each trial divisor takes the remainder in
//   two 5-bit slices (high, then low), tried on i and then on n-i.
// Throughput: one number at a time; the next is taken once its final result is in
//   the output register, which then holds while the next search runs.
// Reset (synchronous, active low) idles the sequencer and drops any held result.
// Depends on gbl_pkg, gbl_if, gbl_ctrl and gbl_dp.
module goldbach_partition_lister_unit
  import gbl_pkg::*;
#(
  parameter int MAX_N = 512
) (
  input  logic             clk,
  input  logic             rst_n,
  gbl_in_if.sink           in_chan,
  gbl_out_if.source        out_chan
);

  cmd_t  cmd;
  stat_t stat;

  gbl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  gbl_dp #(
    .MAX_N (MAX_N)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_n            (in_chan.n),
    .out_valid       (out_chan.valid),
    .out_ready       (out_chan.ready),
    .out_small_prime (out_chan.small_prime),
    .out_large_prime (out_chan.large_prime),
    .out_found       (out_chan.found),
    .out_last        (out_chan.last)
  );

endmodule

### sv/gbl_ctrl.sv
`timescale 1ns / 1ps
// Sequencer of the partition search: walks candidates, trial divisors and output pushes.
// Depends on gbl_pkg for state, command and status types.
module gbl_ctrl
  import gbl_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_CAND;
        end
      end
      ST_CAND: begin
        if (!stat.sel_j && stat.cand_end) begin
          state_nxt = ST_FLUSH;
        end else if (stat.v_lt2) begin
          cmd.next_cand = 1'b1;
        end else begin
          cmd.start_test = 1'b1;
          state_nxt      = ST_DIV_HI;
        end
      end
      ST_DIV_HI: begin
        if (stat.sq_gt) begin
          // value is prime: test the partner next, or record the pair
          if (!stat.sel_j) begin
            cmd.sel_large = 1'b1;
            state_nxt     = ST_CAND;
          end else begin
            state_nxt = ST_PAIR;
          end
        end else begin
          cmd.div_hi = 1'b1;
          state_nxt  = ST_DIV_LO;
        end
      end
      ST_DIV_LO: begin
        if (stat.rem_zero) begin
          cmd.next_cand = 1'b1;
          state_nxt     = ST_CAND;
        end else begin
          cmd.inc_d = 1'b1;
          state_nxt = ST_DIV_HI;
        end
      end
      ST_PAIR: begin
        if (stat.cnt_full) begin
          state_nxt = ST_FLUSH;
        end else if (!stat.has_pend || stat.out_free) begin
          cmd.record_pair = 1'b1;
          cmd.next_cand   = 1'b1;
          state_nxt       = ST_CAND;
        end
      end
      ST_FLUSH: begin
        if (stat.out_free) begin
          cmd.push_final = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

### sv/gbl_dp.sv
`timescale 1ns / 1ps
// Datapath: candidate and divisor registers, sliced remainder unit, pending pair
// and output register. Depends on gbl_pkg; driven by gbl_ctrl commands.
module gbl_dp
  import gbl_pkg::*;
#(
  parameter int MAX_N = 512
) (
  input  logic            clk,
  input  logic            rst_n,
  input  cmd_t            cmd,
  output stat_t           stat,
  input  logic [N_W-1:0]  in_n,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [SP_W-1:0] out_small_prime,
  output logic [LP_W-1:0] out_large_prime,
  output logic            out_found,
  output logic            out_last
);

  localparam logic [N_W+1:0] MAX_N_W = (N_W+2)'(MAX_N);

  // Five restoring-division steps over one slice of the dividend.
  function automatic logic [REM_W-1:0] rem_steps(input logic [REM_W-1:0] r_in,
                                                 input logic [4:0]       bits,
                                                 input logic [D_W-1:0]   dv);
    logic [REM_W:0] r;
    r = {1'b0, r_in};
    for (int k = 4; k >= 0; k--) begin
      r = {r[REM_W-1:0], bits[k]};
      if (r >= {1'b0, dv}) begin
        r = r - {1'b0, dv};
      end
    end
    return r[REM_W-1:0];
  endfunction

  logic [N_W-1:0]   n_r;
  logic [N_W-1:0]   i_r;
  logic             sel_j_r;
  logic [D_W-1:0]   d_r;
  logic [REM_W-1:0] rem_r;
  logic [CNT_W-1:0] cnt_r;
  logic             pend_valid_r;
  logic [SP_W-1:0]  pend_sp_r;
  logic [LP_W-1:0]  pend_lp_r;
  logic             out_valid_r;
  logic [SP_W-1:0]  out_sp_r;
  logic [LP_W-1:0]  out_lp_r;
  logic             out_found_r;
  logic             out_last_r;

  logic [N_W-1:0]   v;
  logic [N_W:0]     vx;
  logic [2*D_W-1:0] sq;
  logic [REM_W-1:0] rem_hi;
  logic [REM_W-1:0] rem_lo;
  logic             n_ok;
  logic             out_free;
  logic             push_mid;
  logic             push;

  assign v      = sel_j_r ? (n_r - i_r) : i_r;
  assign vx     = {1'b0, v};
  assign sq     = {{D_W{1'b0}}, d_r} * {{D_W{1'b0}}, d_r};
  assign rem_hi = rem_steps('0, vx[9:5], d_r);
  assign rem_lo = rem_steps(rem_r, vx[4:0], d_r);
  assign n_ok   = (n_r > FIRST_PRIME) && !n_r[0] && ({2'b00, n_r} < MAX_N_W);

  assign out_free = !out_valid_r || out_ready;
  assign push_mid = cmd.record_pair && pend_valid_r;
  assign push     = push_mid || cmd.push_final;

  assign stat.cand_end = (i_r > {1'b0, n_r[N_W-1:1]}) || !n_ok;
  assign stat.sel_j    = sel_j_r;
  assign stat.v_lt2    = v < FIRST_PRIME;
  assign stat.sq_gt    = sq > {1'b0, v};
  assign stat.rem_zero = rem_lo == '0;
  assign stat.has_pend = pend_valid_r;
  assign stat.out_free = out_free;
  assign stat.cnt_full = cnt_r == MAX_RES;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_j_r      <= 1'b0;
      cnt_r        <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cmd.load) begin
        sel_j_r      <= 1'b0;
        cnt_r        <= '0;
        pend_valid_r <= 1'b0;
      end
      if (cmd.sel_large) begin
        sel_j_r <= 1'b1;
      end
      if (cmd.next_cand) begin
        sel_j_r <= 1'b0;
      end
      if (cmd.record_pair) begin
        cnt_r        <= cnt_r + 1'b1;
        pend_valid_r <= 1'b1;
      end
      if (cmd.push_final) begin
        pend_valid_r <= 1'b0;
      end
      if (push) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      n_r <= in_n;
      i_r <= FIRST_PRIME;
    end else if (cmd.next_cand) begin
      i_r <= i_r + 1'b1;
    end
    if (cmd.start_test) begin
      d_r <= D_W'(FIRST_PRIME);
    end else if (cmd.inc_d) begin
      d_r <= d_r + 1'b1;
    end
    if (cmd.div_hi) begin
      rem_r <= rem_hi;
    end
    if (cmd.record_pair) begin
      pend_sp_r <= i_r[SP_W-1:0];
      pend_lp_r <= v;
    end
    if (push_mid) begin
      out_sp_r    <= pend_sp_r;
      out_lp_r    <= pend_lp_r;
      out_found_r <= 1'b1;
      out_last_r  <= 1'b0;
    end else if (cmd.push_final) begin
      // close the run: pending pair if any, otherwise the empty result
      out_sp_r    <= pend_valid_r ? pend_sp_r : '0;
      out_lp_r    <= pend_valid_r ? pend_lp_r : '0;
      out_found_r <= pend_valid_r;
      out_last_r  <= 1'b1;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_small_prime = out_sp_r;
  assign out_large_prime = out_lp_r;
  assign out_found       = out_found_r;
  assign out_last        = out_last_r;

  a_mid_push_free: assert property (@(posedge clk) disable iff (!rst_n)
    push_mid |-> out_free)
    else $error("pair pushed over an unread result");

  a_final_push_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push_final |-> out_free)
    else $error("final result pushed over an unread result");

  a_final_closes: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push_final |=> (!pend_valid_r && out_valid_r && out_last_r))
    else $error("run not closed after final push");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= MAX_RES)
    else $error("pair count past limit");

  a_load_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> (!pend_valid_r && cnt_r == '0))
    else $error("new number started with stale pair");

endmodule
